// File: src/sn2_pkg.sv
// Shared types, constants and small functions for the 2D simplex noise block.
// Used by every module in src; no other dependencies.
package sn2_pkg;

  localparam int PERM_AW = 8;  // 256-entry permutation table
  localparam int OFS_BITS = 28;  // offsets and falloff are Q28

  // Skew factor (sqrt(3)-1)/2 in Q32 and unskew factor (3-sqrt(3))/6 in Q28.
  localparam logic signed [31:0] SKEW_Q32 = 32'sd1572067139;
  localparam logic [31:0] UNSKEW_Q28 = 32'd56727087;
  localparam logic [31:0] UNSKEW2_Q28 = 32'd113454174;
  localparam logic [31:0] ONE_Q28 = 32'd268435456;

  localparam int D_W = 34;  // dot product of gradient and offset
  localparam int C_W = 60;  // corner contribution t^4 * dot
  localparam int SUM_W = 62;
  localparam int SC_W = 70;  // sum * 70 plus rounding bias
  localparam int OUT_SHIFT = 41;
  localparam int OUT_W = 16;

  // Gradient component codes.
  localparam logic [1:0] GC_ZERO = 2'b00;
  localparam logic [1:0] GC_POS = 2'b01;
  localparam logic [1:0] GC_NEG = 2'b11;

  typedef struct packed {
    logic [1:0] gx;
    logic [1:0] gy;
  } grad_t;

  // Byte modulo 12: (b / 4) / 3 by a multiply with 43/128, exact for b / 4 below 64.
  function automatic logic [3:0] grad_sel(input logic [7:0] b);
    logic [11:0] m;
    logic [4:0] q;
    logic [7:0] r;
    m = 12'(b[7:2]) * 12'd43;
    q = m[11:7];
    r = b - (8'(q) * 8'd12);
    return r[3:0];
  endfunction

  function automatic grad_t grad_vec(input logic [3:0] g);
    grad_t v;
    unique case (g)
      4'd0: v = '{gx: GC_POS, gy: GC_POS};
      4'd1: v = '{gx: GC_NEG, gy: GC_POS};
      4'd2: v = '{gx: GC_POS, gy: GC_NEG};
      4'd3: v = '{gx: GC_NEG, gy: GC_NEG};
      4'd4: v = '{gx: GC_POS, gy: GC_ZERO};
      4'd5: v = '{gx: GC_NEG, gy: GC_ZERO};
      4'd6: v = '{gx: GC_POS, gy: GC_ZERO};
      4'd7: v = '{gx: GC_NEG, gy: GC_ZERO};
      4'd8: v = '{gx: GC_ZERO, gy: GC_POS};
      4'd9: v = '{gx: GC_ZERO, gy: GC_NEG};
      4'd10: v = '{gx: GC_ZERO, gy: GC_POS};
      4'd11: v = '{gx: GC_ZERO, gy: GC_NEG};
      default: v = '{gx: GC_ZERO, gy: GC_ZERO};
    endcase
    return v;
  endfunction

endpackage

// File: src/sn2_perm_mem.sv
// One copy of the 256 x 8 permutation table: one write port, two read ports,
// registered read data. Depends on sn2_pkg.
module sn2_perm_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [sn2_pkg::PERM_AW-1:0]   wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic [sn2_pkg::PERM_AW-1:0]   rd_addr0,
  input  logic [sn2_pkg::PERM_AW-1:0]   rd_addr1,
  output logic [7:0]                    rd_data0,
  output logic [7:0]                    rd_data1
);

  logic [7:0] mem [2**sn2_pkg::PERM_AW];
  logic [7:0] rd0_r;
  logic [7:0] rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_r <= mem[rd_addr0];
    rd1_r <= mem[rd_addr1];
  end

  assign rd_data0 = rd0_r;
  assign rd_data1 = rd1_r;

endmodule

// File: src/sn2_skew.sv
// Coordinate front end: skew, floor to the cell, and first-corner offsets in Q28.
// Stages 1 to 6 of the pipeline. Depends on sn2_pkg.
module sn2_skew #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic signed [31:0]                  x_pos,
  input  logic signed [31:0]                  y_pos,
  output logic [sn2_pkg::PERM_AW-1:0]         j_cell,
  output logic [sn2_pkg::PERM_AW-1:0]         i_cell,
  output logic signed [31:0]                  x0,
  output logic signed [31:0]                  y0
);

  localparam int CELL_W = 33 - POS_FRAC_BITS;
  localparam int UP = sn2_pkg::OFS_BITS - POS_FRAC_BITS;

  logic signed [31:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [31:0] x4_r, y4_r;
  logic signed [32:0] sxy;
  logic signed [32:0] sxy2_r;
  logic signed [63:0] prod;
  logic signed [31:0] s3_r;
  logic signed [32:0] ax, ay;
  logic signed [CELL_W-1:0] i4_r, j4_r;
  logic [31:0] ie, je, ij, uns, xs, ys;
  logic [31:0] xs5_r, ys5_r, uns5_r;
  logic [sn2_pkg::PERM_AW-1:0] i5_r, i6_r;
  logic [31:0] x0_r, y0_r;

  assign sxy = 33'(x1_r) + 33'(y1_r);
  assign prod = 64'(sxy2_r) * 64'(sn2_pkg::SKEW_Q32);
  assign ax = 33'(x3_r) + 33'(s3_r);
  assign ay = 33'(y3_r) + 33'(s3_r);

  assign ie = 32'(i4_r);
  assign je = 32'(j4_r);
  assign ij = ie + je;
  assign uns = ij * sn2_pkg::UNSKEW_Q28;
  assign xs = (x4_r << UP) - {ie[31-sn2_pkg::OFS_BITS:0], {sn2_pkg::OFS_BITS{1'b0}}};
  assign ys = (y4_r << UP) - {je[31-sn2_pkg::OFS_BITS:0], {sn2_pkg::OFS_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    x1_r   <= x_pos;
    y1_r   <= y_pos;
    sxy2_r <= sxy;
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    s3_r   <= prod[63:32];
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    i4_r   <= ax[32:POS_FRAC_BITS];
    j4_r   <= ay[32:POS_FRAC_BITS];
    x4_r   <= x3_r;
    y4_r   <= y3_r;
    xs5_r  <= xs;
    ys5_r  <= ys;
    uns5_r <= uns;
    i5_r   <= i4_r[sn2_pkg::PERM_AW-1:0];
    x0_r   <= xs5_r + uns5_r;
    y0_r   <= ys5_r + uns5_r;
    i6_r   <= i5_r;
  end

  assign j_cell = j4_r[sn2_pkg::PERM_AW-1:0];
  assign i_cell = i6_r;
  assign x0 = $signed(x0_r);
  assign y0 = $signed(y0_r);

endmodule

// File: src/sn2_corner.sv
// One corner lane: gradient pick, falloff t^4 and contribution t^4 * dot.
// Five register stages, four of them fed by a multiplier. Depends on sn2_pkg.
module sn2_corner (
  input  logic                              clk,
  input  logic signed [31:0]                ox,
  input  logic signed [31:0]                oy,
  input  logic [7:0]                        perm_byte,
  output logic signed [sn2_pkg::C_W-1:0]    contrib
);

  localparam logic signed [35:0] T_HALF = 36'sd1 <<< (sn2_pkg::OFS_BITS - 1);

  sn2_pkg::grad_t gv, gv_r;
  logic signed [63:0] sqx_full, sqy_full;
  logic [33:0] sqx_r, sqy_r;
  logic signed [31:0] ox8_r, oy8_r;
  logic signed [35:0] t;
  logic [27:0] tpos, t9_r;
  logic signed [sn2_pkg::D_W-1:0] dx, dy, d, d9_r, d10_r, d11_r;
  logic [55:0] t2_full;
  logic [26:0] t2_r;
  logic [53:0] t4_full;
  logic [24:0] t4_r;
  logic signed [sn2_pkg::C_W-1:0] c, c_r;

  assign gv = sn2_pkg::grad_vec(sn2_pkg::grad_sel(perm_byte));
  assign sqx_full = 64'(ox) * 64'(ox);
  assign sqy_full = 64'(oy) * 64'(oy);

  assign t = T_HALF - $signed({2'b00, sqx_r}) - $signed({2'b00, sqy_r});
  // A corner outside the falloff radius contributes nothing: t forced to zero.
  assign tpos = (t > 36'sd0) ? t[27:0] : 28'd0;

  always_comb begin
    case (gv_r.gx)
      sn2_pkg::GC_POS: dx = sn2_pkg::D_W'(ox8_r);
      sn2_pkg::GC_NEG: dx = -sn2_pkg::D_W'(ox8_r);
      default:         dx = '0;
    endcase
    case (gv_r.gy)
      sn2_pkg::GC_POS: dy = sn2_pkg::D_W'(oy8_r);
      sn2_pkg::GC_NEG: dy = -sn2_pkg::D_W'(oy8_r);
      default:         dy = '0;
    endcase
    d = dx + dy;
  end

  assign t2_full = 56'(t9_r) * 56'(t9_r);
  assign t4_full = 54'(t2_r) * 54'(t2_r);
  assign c = sn2_pkg::C_W'($signed({1'b0, t4_r})) * sn2_pkg::C_W'(d11_r);

  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[61:28];
    sqy_r <= sqy_full[61:28];
    gv_r  <= gv;
    ox8_r <= ox;
    oy8_r <= oy;
    t9_r  <= tpos;
    d9_r  <= d;
    t2_r  <= t2_full[54:28];
    d10_r <= d9_r;
    t4_r  <= t4_full[52:28];
    d11_r <= d10_r;
    c_r   <= c;
  end

  assign contrib = c_r;

endmodule

// File: src/simplex_noise_2d.sv
// Top level of the 2D simplex noise evaluator with loadable permutation table.
// Depends on sn2_pkg, sn2_perm_mem, sn2_skew and sn2_corner.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   input    | start, busy          | in_op, in_x_pos, in_y_pos, in_perm_index/value
//   result   | out_valid (strobe)   | out_noise_value
//
// A beat is taken every cycle; busy stays low. An evaluate beat gives its result
// through the fifteen-stage pipeline (coordinate skew, two permutation memory
// reads, four multiplier stages per corner, sum and scale). A load beat writes each
// table copy when it reaches that copy's read stage, so beats see the table in
// acceptance order. rst_n clears only the pipeline valid bits; the table holds
// nothing defined until loaded. The receiver cannot stall.
module simplex_noise_2d #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic signed [31:0]    in_x_pos,
  input  logic signed [31:0]    in_y_pos,
  input  logic [7:0]            in_perm_index,
  input  logic [7:0]            in_perm_value,
  output logic                  out_valid,
  output logic signed [15:0]    out_noise_value
);

  localparam int PIPE_DEPTH = 15;
  localparam int WR_A_STAGE = 4;
  localparam int WR_BC_STAGE = 6;
  localparam int AW = sn2_pkg::PERM_AW;
  localparam int RQ_W = sn2_pkg::SC_W - sn2_pkg::OUT_SHIFT;

  logic accept;
  logic [PIPE_DEPTH:1] eval_r;
  logic [WR_BC_STAGE:1] ld_r;
  logic [7:0] idx_r [WR_BC_STAGE:1];
  logic [7:0] val_r [WR_BC_STAGE:1];

  logic [AW-1:0] j_cell, i_cell, j_cell_p1;
  logic signed [31:0] x0, y0;
  logic [7:0] pa0, pa1, pj0_r, pj1_r;
  logic di;
  logic [AW-1:0] a0, a1, a2;
  logic signed [31:0] ox [3];
  logic signed [31:0] oy [3];
  logic signed [31:0] ox7_r [3];
  logic signed [31:0] oy7_r [3];
  logic [7:0] pb [3];
  logic signed [sn2_pkg::C_W-1:0] contrib [3];
  logic signed [sn2_pkg::SUM_W-1:0] sum, sum_r;
  logic signed [sn2_pkg::SC_W-1:0] sum_ext, scaled, scaled_r;
  logic signed [RQ_W-1:0] rq;
  logic signed [15:0] noise_nxt, noise_r;

  assign busy = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r <= '0;
      ld_r   <= '0;
    end else begin
      eval_r <= {eval_r[PIPE_DEPTH-1:1], accept && !in_op};
      ld_r   <= {ld_r[WR_BC_STAGE-1:1], accept && in_op};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[1] <= in_perm_index;
    val_r[1] <= in_perm_value;
    for (int k = 2; k <= WR_BC_STAGE; k++) begin
      idx_r[k] <= idx_r[k-1];
      val_r[k] <= val_r[k-1];
    end
  end

  sn2_skew #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_skew (
    .clk    (clk),
    .x_pos  (in_x_pos),
    .y_pos  (in_y_pos),
    .j_cell (j_cell),
    .i_cell (i_cell),
    .x0     (x0),
    .y0     (y0)
  );

  assign j_cell_p1 = j_cell + AW'(1);

  // First-level lookups perm[j] and perm[j+1], read in stage 4.
  sn2_perm_mem u_mem_a (
    .clk      (clk),
    .wr_en    (ld_r[WR_A_STAGE]),
    .wr_addr  (idx_r[WR_A_STAGE]),
    .wr_data  (val_r[WR_A_STAGE]),
    .rd_addr0 (j_cell),
    .rd_addr1 (j_cell_p1),
    .rd_data0 (pa0),
    .rd_data1 (pa1)
  );

  always_ff @(posedge clk) begin
    pj0_r <= pa0;
    pj1_r <= pa1;
  end

  // Stage 6: pick the triangle, form the three hash addresses and the offsets.
  assign di = x0 > y0;
  assign a0 = i_cell + pj0_r;
  assign a1 = di ? (i_cell + pj0_r + AW'(1)) : (i_cell + pj1_r);
  assign a2 = i_cell + pj1_r + AW'(1);

  always_comb begin
    ox[0] = x0;
    oy[0] = y0;
    ox[1] = x0 - (di ? $signed(sn2_pkg::ONE_Q28) : 32'sd0) + $signed(sn2_pkg::UNSKEW_Q28);
    oy[1] = y0 - (di ? 32'sd0 : $signed(sn2_pkg::ONE_Q28)) + $signed(sn2_pkg::UNSKEW_Q28);
    ox[2] = x0 - $signed(sn2_pkg::ONE_Q28) + $signed(sn2_pkg::UNSKEW2_Q28);
    oy[2] = y0 - $signed(sn2_pkg::ONE_Q28) + $signed(sn2_pkg::UNSKEW2_Q28);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ox7_r[k] <= ox[k];
      oy7_r[k] <= oy[k];
    end
  end

  // Second-level lookups, read in stage 6 from two more copies of the table.
  sn2_perm_mem u_mem_b (
    .clk      (clk),
    .wr_en    (ld_r[WR_BC_STAGE]),
    .wr_addr  (idx_r[WR_BC_STAGE]),
    .wr_data  (val_r[WR_BC_STAGE]),
    .rd_addr0 (a0),
    .rd_addr1 (a1),
    .rd_data0 (pb[0]),
    .rd_data1 (pb[1])
  );

  sn2_perm_mem u_mem_c (
    .clk      (clk),
    .wr_en    (ld_r[WR_BC_STAGE]),
    .wr_addr  (idx_r[WR_BC_STAGE]),
    .wr_data  (val_r[WR_BC_STAGE]),
    .rd_addr0 (a2),
    .rd_addr1 (a2),
    .rd_data0 (pb[2]),
    .rd_data1 ()
  );

  for (genvar g = 0; g < 3; g++) begin : g_corner
    sn2_corner u_corner (
      .clk       (clk),
      .ox        (ox7_r[g]),
      .oy        (oy7_r[g]),
      .perm_byte (pb[g]),
      .contrib   (contrib[g])
    );
  end

  assign sum = sn2_pkg::SUM_W'(contrib[0]) + sn2_pkg::SUM_W'(contrib[1])
             + sn2_pkg::SUM_W'(contrib[2]);
  assign sum_ext = sn2_pkg::SC_W'(sum_r);
  // Times 70 as 64 + 4 + 2, plus half an output LSB for round half up.
  assign scaled = (sum_ext <<< 6) + (sum_ext <<< 2) + (sum_ext <<< 1)
                + (sn2_pkg::SC_W'(1) <<< (sn2_pkg::OUT_SHIFT - 1));
  assign rq = scaled_r[sn2_pkg::SC_W-1:sn2_pkg::OUT_SHIFT];

  always_comb begin
    if (rq > RQ_W'(32767)) begin
      noise_nxt = 16'sh7fff;
    end else if (rq < -RQ_W'(32768)) begin
      noise_nxt = -16'sh8000;
    end else begin
      noise_nxt = rq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum;
    scaled_r <= scaled;
    noise_r  <= noise_nxt;
  end

  assign out_valid = eval_r[PIPE_DEPTH];
  assign out_noise_value = noise_r;

endmodule
